// ===== design/blinn_phong_ascii_shader_defines.svh =====
// ----------------------------------------------------------------------------
// shader assertion macros
// shared concurrent checks, sampled on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef BLINN_PHONG_ASCII_SHADER_DEFINES_SVH
`define BLINN_PHONG_ASCII_SHADER_DEFINES_SVH

// condition holds at every edge
`define BPS_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("%m: check failed");

// condition holds at the edge after the trigger
`define BPS_ASSERT_NEXT(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("%m: check failed");

`endif

// ===== design/bps_pkg.sv =====
// ----------------------------------------------------------------------------
// bps_pkg
// shared types, constants and tables of the ascii blinn-phong shader
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int MAT_LIMIT = 9;

	localparam logic [14:0] ONE_F = 15'd16384;
	localparam logic [30:0] FOG_ONE = 31'h4000_0000;
	localparam logic [28:0] INV_E = 29'd395007542;
	localparam logic [5:0] FOG_K_LIMIT = 6'd12;
	localparam logic [14:0] CS_BASE = 15'd4915;
	localparam logic [14:0] CS_SLOPE = 15'd11469;

	localparam logic [15:0] RST_LIGHT_X = 16'd7077;
	localparam logic [15:0] RST_LIGHT_Y = 16'd14154;
	localparam logic [15:0] RST_LIGHT_Z = 16'd4246;
	localparam logic [14:0] RST_AMBIENT = 15'd3277;
	localparam logic [14:0] RST_DIFFUSE = 15'd9830;
	localparam logic [14:0] RST_SPECULAR = 15'd4915;
	localparam logic [15:0] RST_FOG_RATE = 16'd3277;

	typedef enum logic [2:0] {
		REG_LIGHT_X,
		REG_LIGHT_Y,
		REG_LIGHT_Z,
		REG_AMBIENT,
		REG_DIFFUSE,
		REG_SPECULAR,
		REG_FOG_RATE
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] light_x;
		logic signed [15:0] light_y;
		logic signed [15:0] light_z;
		logic [14:0] ambient;
		logic [14:0] diffuse_gain;
		logic [14:0] specular_gain;
		logic [15:0] fog_rate;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic signed [16:0] hx;
		logic signed [16:0] hy;
		logic signed [16:0] hz;
		logic [3:0] mat;
		logic [15:0] dst;
	} qent_t;

	function automatic logic [8:0] mat_rgb(input logic [3:0] idx);
		case (idx)
			4'd1: return {3'd5, 3'd1, 3'd1};
			4'd2: return {3'd1, 3'd3, 3'd5};
			4'd3: return {3'd5, 3'd4, 3'd0};
			4'd4: return {3'd5, 3'd5, 3'd0};
			4'd5: return {3'd5, 3'd0, 3'd5};
			4'd6: return {3'd0, 3'd5, 3'd5};
			4'd7: return {3'd2, 3'd5, 3'd2};
			4'd8: return {3'd5, 3'd2, 3'd3};
			default: return {3'd2, 3'd3, 3'd2};
		endcase
	endfunction

	function automatic logic [6:0] ramp_glyph(input logic [3:0] lvl);
		case (lvl)
			4'd1: return 7'd46;
			4'd2: return 7'd58;
			4'd3: return 7'd45;
			4'd4: return 7'd61;
			4'd5: return 7'd43;
			4'd6: return 7'd42;
			4'd7: return 7'd35;
			4'd8: return 7'd37;
			4'd9: return 7'd64;
			default: return 7'd32;
		endcase
	endfunction

endpackage

`default_nettype wire

// ===== design/bps_front.sv =====
// ----------------------------------------------------------------------------
// bps_front
// input register: forms the half vector and resolves the material index
// ----------------------------------------------------------------------------
`default_nettype none

module bps_front import bps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               pixel_valid,
	output logic               pixel_stall,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic signed [15:0] ray_x,
	input  logic signed [15:0] ray_y,
	input  logic signed [15:0] ray_z,
	input  logic [3:0]         mat_sel,
	input  logic [15:0]        hit_distance,
	output logic               push,
	output qent_t              push_ent,
	input  logic               q_full
);

	logic  v_s1;
	qent_t ent_s1;

	assign pixel_stall = v_s1 & q_full;
	assign push = v_s1 & ~q_full;
	assign push_ent = ent_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!pixel_stall) begin
			v_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel_valid && !pixel_stall) begin
			ent_s1.nx <= normal_x;
			ent_s1.ny <= normal_y;
			ent_s1.nz <= normal_z;
			ent_s1.hx <= $signed({cfg.light_x[15], cfg.light_x}) - $signed({ray_x[15], ray_x});
			ent_s1.hy <= $signed({cfg.light_y[15], cfg.light_y}) - $signed({ray_y[15], ray_y});
			ent_s1.hz <= $signed({cfg.light_z[15], cfg.light_z}) - $signed({ray_z[15], ray_z});
			ent_s1.mat <= ({1'b0, mat_sel} < 5'(MAT_LIMIT)) ? mat_sel : 4'd0;
			ent_s1.dst <= hit_distance;
		end
	end

endmodule

`default_nettype wire

// ===== design/bps_queue.sv =====
// ----------------------------------------------------------------------------
// bps_queue
// short register queue between the front register and the shading pipeline
// ----------------------------------------------------------------------------
`default_nettype none
`include "blinn_phong_ascii_shader_defines.svh"

module bps_queue import bps_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t push_ent,
	output logic  full,
	input  logic  pop,
	output qent_t head,
	output logic  empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	qent_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_ent;
		end
	end

	`BPS_ASSERT_ALWAYS(a_cnt_range, cnt_q <= CW'(DEPTH))
	`BPS_ASSERT_ALWAYS(a_no_pop_empty, !(pop && empty))
	`BPS_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_q == $past(cnt_q) + 1'b1)
	`BPS_ASSERT_NEXT(a_cnt_dn, pop && !push, cnt_q == $past(cnt_q) - 1'b1)

endmodule

`default_nettype wire

// ===== design/bps_back.sv =====
// ----------------------------------------------------------------------------
// bps_back
// shading pipeline: dot products, square root, divide, power, fog, ramp
// ----------------------------------------------------------------------------
`default_nettype none

module bps_back import bps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  qent_t       head,
	input  logic        q_empty,
	output logic        pop,
	output logic        shade_valid,
	input  logic        shade_stall,
	output logic [3:0]  ramp_level,
	output logic [6:0]  glyph_code,
	output logic [7:0]  fg_color
);

	localparam int S_PROD = 0;
	localparam int S_SUM = 1;
	localparam int S_D1 = 2;
	localparam int S_D2 = 3;
	localparam int SQ0 = 2;
	localparam int HN0 = 2;
	localparam int S_DIVPRE = 19;
	localparam int DV0 = 20;
	localparam int EX0 = 26;
	localparam int S_SQR0 = 35;
	localparam int S_SPEC = 39;
	localparam int S_SUMALL = 40;
	localparam int S_LMUL = 41;
	localparam int S_LUM = 42;
	localparam int S_LVL = 43;
	localparam int S_CH = 44;
	localparam int S_COL = 45;
	localparam int DEPTH = 46;

	localparam logic [32:0] MREC [8] = '{
		33'd536870912, 33'd613566756, 33'd715827882, 33'd858993459,
		33'd1073741824, 33'd1431655765, 33'd2147483648, 33'd4294967296
	};

	typedef struct {
		logic signed [15:0] nx, ny, nz;
		logic signed [16:0] hx, hy, hz;
		logic [3:0]         mat;
		logic [15:0]        dst;
		logic signed [31:0] pnl0, pnl1, pnl2;
		logic signed [32:0] pnh0, pnh1, pnh2;
		logic [31:0]        phh0, phh1, phh2;
		logic [31:0]        fx;
		logic signed [33:0] dnl;
		logic signed [34:0] dnh;
		logic [33:0]        hh;
		logic [5:0]         k;
		logic [15:0]        f;
		logic               fz;
		logic [17:0]        d1;
		logic [19:0]        diff;
		logic [34:0]        sv, sr;
		logic [16:0]        len;
		logic [30:0]        rem;
		logic               over, spz;
		logic [14:0]        q, c, spec;
		logic [30:0]        fp, ft;
		logic [31:0]        fq;
		logic [20:0]        sum;
		logic [30:0]        fog;
		logic [51:0]        lp;
		logic [14:0]        lum, cs;
		logic [3:0]         level;
		logic [2:0]         ch_r, ch_g, ch_b;
		logic [6:0]         glyph;
		logic [7:0]         color;
	} bk_t;

	function automatic logic [2:0] chan(input logic [2:0] m, input logic [14:0] cs);
		logic [17:0] p;
		p = {15'd0, m} * {3'd0, cs};
		return (p[17:14] > 4'd5) ? 3'd5 : p[16:14];
	endfunction

	function automatic bk_t step(input bk_t c, input int i, input cfg_t cr);
		bk_t         n;
		logic [63:0] w;
		logic [63:0] w2;
		logic [34:0] sv;
		logic [34:0] sr;
		logic [34:0] bitc;
		logic [30:0] dsub;
		logic [47:0] num;
		logic [31:0] lim;
		logic [14:0] c0;
		logic [33:0] rr;
		logic [31:0] qq;
		logic [8:0]  rgb;
		n = c;
		if (i == S_PROD) begin
			n.pnl0 = $signed(c.nx) * $signed(cr.light_x);
			n.pnl1 = $signed(c.ny) * $signed(cr.light_y);
			n.pnl2 = $signed(c.nz) * $signed(cr.light_z);
			n.pnh0 = $signed(c.nx) * $signed(c.hx);
			n.pnh1 = $signed(c.ny) * $signed(c.hy);
			n.pnh2 = $signed(c.nz) * $signed(c.hz);
			n.phh0 = $signed(c.hx) * $signed(c.hx);
			n.phh1 = $signed(c.hy) * $signed(c.hy);
			n.phh2 = $signed(c.hz) * $signed(c.hz);
			n.fx = cr.fog_rate * c.dst;
		end
		if (i == S_SUM) begin
			n.dnl = c.pnl0 + c.pnl1 + c.pnl2;
			n.dnh = c.pnh0 + c.pnh1 + c.pnh2;
			n.hh = {2'b00, c.phh0} + {2'b00, c.phh1} + {2'b00, c.phh2};
			n.k = c.fx[31:26];
			n.f = c.fx[25:10];
			n.fz = (c.fx[31:26] >= FOG_K_LIMIT);
		end
		if (i == S_D1) begin
			w = {31'd0, c.dnl[32:0]} + 64'd8192;
			n.d1 = (c.dnl > 0) ? w[31:14] : 18'd0;
		end
		if (i == S_D2) begin
			w = 64'(c.d1) * 64'(cr.diffuse_gain) + 64'd8192;
			n.diff = w[33:14];
		end
		for (int j = 0; j < 17; j++) begin
			if (i == SQ0 + j) begin
				sv = (j == 0) ? {1'b0, c.hh} : c.sv;
				sr = (j == 0) ? 35'd0 : c.sr;
				bitc = 35'd1 << (32 - 2 * j);
				if (sv >= sr + bitc) begin
					n.sv = sv - (sr + bitc);
					n.sr = (sr >> 1) + bitc;
				end else begin
					n.sv = sv;
					n.sr = sr >> 1;
				end
			end
		end
		if (i == S_DIVPRE) begin
			n.len = c.sr[16:0];
			num = {c.dnh[33:0], 14'd0} + {32'd0, c.sr[16:1]};
			lim = {1'b0, c.sr[16:0], 14'd0} + {15'd0, c.sr[16:0]};
			n.over = (num >= {16'd0, lim});
			n.spz = (c.dnh <= 0) || (c.hh == '0);
			n.rem = num[30:0];
			n.q = '0;
		end
		for (int j = 0; j < 15; j++) begin
			if (i == DV0 + j) begin
				dsub = {14'd0, c.len} << (14 - j);
				if (c.rem >= dsub) begin
					n.rem = c.rem - dsub;
					n.q[14 - j] = 1'b1;
				end
			end
		end
		for (int j = 0; j < 4; j++) begin
			if (i == S_SQR0 + j) begin
				c0 = (j == 0) ? (c.over ? ONE_F : c.q) : c.c;
				w = 64'(c0) * 64'(c0) + 64'd8192;
				n.c = w[28:14];
			end
		end
		if (i == S_SPEC) begin
			w = 64'(c.c) * 64'(cr.specular_gain) + 64'd8192;
			n.spec = c.spz ? 15'd0 : w[28:14];
		end
		for (int u = 0; u < 8; u++) begin
			if (i == HN0 + 3 * u) begin
				w = 64'(c.f) * 64'((u == 0) ? FOG_ONE : c.ft);
				n.fp = w[46:16];
			end
			if (i == HN0 + 3 * u + 1) begin
				w = 64'(c.fp) * 64'(MREC[u]);
				n.fq = w[63:32];
			end
			if (i == HN0 + 3 * u + 2) begin
				rr = 34'(c.fp) - 34'(c.fq) * 34'(8 - u);
				qq = (rr >= 34'(8 - u)) ? c.fq + 32'd1 : c.fq;
				n.ft = FOG_ONE - qq[30:0];
			end
		end
		for (int j = 0; j < 11; j++) begin
			if (i == EX0 + j) begin
				if (c.k > 6'(j)) begin
					w = 64'(c.ft) * 64'(INV_E) + 64'h2000_0000;
					n.ft = w[60:30];
				end
			end
		end
		if (i == S_SUMALL) begin
			n.sum = 21'(cr.ambient) + 21'(c.diff) + 21'(c.spec);
			n.fog = c.fz ? 31'd0 : c.ft;
		end
		if (i == S_LMUL) begin
			w = 64'(c.sum) * 64'(c.fog);
			n.lp = w[51:0];
		end
		if (i == S_LUM) begin
			w = (64'(c.lp) + 64'h2000_0000) >> 30;
			n.lum = (w > 64'(ONE_F)) ? ONE_F : w[14:0];
		end
		if (i == S_LVL) begin
			w = 64'(c.lum) * 64'd9 + 64'd8192;
			n.level = (w[63:14] > 50'd9) ? 4'd9 : w[17:14];
			w2 = 64'(CS_SLOPE) * 64'(c.lum) + 64'd8192;
			n.cs = CS_BASE + w2[28:14];
		end
		if (i == S_CH) begin
			rgb = mat_rgb(c.mat);
			n.ch_r = chan(rgb[8:6], c.cs);
			n.ch_g = chan(rgb[5:3], c.cs);
			n.ch_b = chan(rgb[2:0], c.cs);
			n.glyph = ramp_glyph(c.level);
		end
		if (i == S_COL) begin
			n.color = 8'd16 + 8'd36 * {5'd0, c.ch_r} + 8'd6 * {5'd0, c.ch_g} + {5'd0, c.ch_b};
		end
		return n;
	endfunction

	bk_t              head_bk;
	bk_t              st [1:DEPTH];
	bk_t              nxt [0:DEPTH-1];
	logic [DEPTH:1]   v_q;
	logic             en;

	assign en = ~(v_q[DEPTH] & shade_stall);
	assign pop = en & ~q_empty;

	always_comb begin
		head_bk = '{default: '0};
		head_bk.nx = head.nx;
		head_bk.ny = head.ny;
		head_bk.nz = head.nz;
		head_bk.hx = head.hx;
		head_bk.hy = head.hy;
		head_bk.hz = head.hz;
		head_bk.mat = head.mat;
		head_bk.dst = head.dst;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_stage
		if (i == 0) begin : g_first
			assign nxt[i] = step(head_bk, i, cfg);
		end else begin : g_rest
			assign nxt[i] = step(st[i], i, cfg);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[DEPTH-1:1], ~q_empty};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 1; k <= DEPTH; k++) begin
				st[k] <= nxt[k-1];
			end
		end
	end

	assign shade_valid = v_q[DEPTH];
	assign ramp_level = st[DEPTH].level;
	assign glyph_code = st[DEPTH].glyph;
	assign fg_color = st[DEPTH].color;

endmodule

`default_nettype wire

// ===== design/blinn_phong_ascii_shader.sv =====
// ----------------------------------------------------------------------------
// blinn_phong_ascii_shader
// per-pixel blinn-phong luminance with fog, ascii ramp glyph and palette color
//
//   channel   role     handshake                 word
//   pixel     in       pixel_valid/pixel_stall   normal, ray, material, distance
//   shade     out      shade_valid/shade_stall   ramp level, glyph, color
//   cfg       in       cfg_write                 register index and data
//
// one word per cycle sustained while shade_stall is low; the pipeline depth is set
// by the 17-step square root and 15-step divide in the specular path
// arst_n clears all control state and loads the register reset values
// a stalled shade word freezes the shading pipeline; the queue and the front
// register absorb QUEUE_DEPTH_P plus one words before pixel_stall rises
// ----------------------------------------------------------------------------
`default_nettype none

module blinn_phong_ascii_shader import bps_pkg::*; #(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               pixel_valid,
	output logic               pixel_stall,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic signed [15:0] ray_x,
	input  logic signed [15:0] ray_y,
	input  logic signed [15:0] ray_z,
	input  logic [3:0]         mat_sel,
	input  logic [15:0]        hit_distance,
	output logic               shade_valid,
	input  logic               shade_stall,
	output logic [3:0]         ramp_level,
	output logic [6:0]         glyph_code,
	output logic [7:0]         fg_color
);

	cfg_t  cfg_q;
	logic  push;
	qent_t push_ent;
	logic  q_full;
	logic  q_empty;
	logic  pop;
	qent_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.light_x <= RST_LIGHT_X;
			cfg_q.light_y <= RST_LIGHT_Y;
			cfg_q.light_z <= RST_LIGHT_Z;
			cfg_q.ambient <= RST_AMBIENT;
			cfg_q.diffuse_gain <= RST_DIFFUSE;
			cfg_q.specular_gain <= RST_SPECULAR;
			cfg_q.fog_rate <= RST_FOG_RATE;
		end else if (cfg_write) begin
			case (reg_idx_t'(cfg_index))
				REG_LIGHT_X: cfg_q.light_x <= cfg_data;
				REG_LIGHT_Y: cfg_q.light_y <= cfg_data;
				REG_LIGHT_Z: cfg_q.light_z <= cfg_data;
				REG_AMBIENT: cfg_q.ambient <= cfg_data[14:0];
				REG_DIFFUSE: cfg_q.diffuse_gain <= cfg_data[14:0];
				REG_SPECULAR: cfg_q.specular_gain <= cfg_data[14:0];
				REG_FOG_RATE: cfg_q.fog_rate <= cfg_data;
				default: ;
			endcase
		end
	end

	bps_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.normal_x     (normal_x),
		.normal_y     (normal_y),
		.normal_z     (normal_z),
		.ray_x        (ray_x),
		.ray_y        (ray_y),
		.ray_z        (ray_z),
		.mat_sel      (mat_sel),
		.hit_distance (hit_distance),
		.push         (push),
		.push_ent     (push_ent),
		.q_full       (q_full)
	);

	bps_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	bps_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head        (head),
		.q_empty     (q_empty),
		.pop         (pop),
		.shade_valid (shade_valid),
		.shade_stall (shade_stall),
		.ramp_level  (ramp_level),
		.glyph_code  (glyph_code),
		.fg_color    (fg_color)
	);

endmodule

`default_nettype wire

// ===== bench/blinn_phong_ascii_shader_check.sv =====
// ----------------------------------------------------------------------------
// blinn_phong_ascii_shader_check
// watches the pixel, shade and cfg ports of the shader, keeps its own copy of
// the registers, predicts the shade word of every accepted pixel word and
// compares each accepted shade word field by field, oldest first
// ----------------------------------------------------------------------------
`default_nettype none

module blinn_phong_ascii_shader_check import bps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               pixel_valid,
	input  logic               pixel_stall,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic signed [15:0] ray_x,
	input  logic signed [15:0] ray_y,
	input  logic signed [15:0] ray_z,
	input  logic [3:0]         mat_sel,
	input  logic [15:0]        hit_distance,
	input  logic               shade_valid,
	input  logic               shade_stall,
	input  logic [3:0]         ramp_level,
	input  logic [6:0]         glyph_code,
	input  logic [7:0]         fg_color,
	output int                 failures,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [3:0] level;
		logic [6:0] glyph;
		logic [7:0] color;
	} shade_t;

	localparam string RAMP = " .:-=+*#%@";
	localparam int FRAC = 14;
	localparam longint unsigned ONE = 64'd1 << FRAC;
	localparam longint unsigned UNIT30 = 64'd1 << 30;
	localparam longint unsigned INV_E_Q30 = 64'd395007542;
	localparam int LISTED = 9;
	localparam logic [2:0] MAT_RGB [0:8][0:2] = '{
		'{3'd2, 3'd3, 3'd2}, '{3'd5, 3'd1, 3'd1}, '{3'd1, 3'd3, 3'd5},
		'{3'd5, 3'd4, 3'd0}, '{3'd5, 3'd5, 3'd0}, '{3'd5, 3'd0, 3'd5},
		'{3'd0, 3'd5, 3'd5}, '{3'd2, 3'd5, 3'd2}, '{3'd5, 3'd2, 3'd3}
	};

	logic signed [15:0] lgt_x, lgt_y, lgt_z;
	logic [14:0] amb, gain_d, gain_s;
	logic [15:0] fog_k;

	shade_t expected_shades[$];

	function automatic longint unsigned round_shift(longint unsigned x, int k);
		return (x + (64'd1 << (k - 1))) >> k;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned r, bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= r + bitv) begin
				v = v - (r + bitv);
				r = (r >> 1) + bitv;
			end else begin
				r = r >> 1;
			end
			bitv = bitv >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned fog_attenuation(logic [15:0] dst);
		longint unsigned x, k, f, t;
		x = longint'(fog_k) * longint'(dst);
		k = x >> 26;
		f = (x & ((64'd1 << 26) - 1)) >> 10;
		t = UNIT30;
		if (k >= 12)
			return 0;
		for (int n = 8; n >= 1; n--)
			t = UNIT30 - ((f * t) >> 16) / n;
		while (k > 0) begin
			t = round_shift(t * INV_E_Q30, 30);
			k--;
		end
		return t;
	endfunction

	function automatic shade_t predict_shade(
		logic signed [15:0] nx, logic signed [15:0] ny, logic signed [15:0] nz,
		logic signed [15:0] rx, logic signed [15:0] ry, logic signed [15:0] rz,
		logic [3:0] mat, logic [15:0] dst
	);
		longint lx, ly, lz, hx, hy, hz, dnl, dnh;
		longint unsigned hh, diff, spec, len, c, sum, lum, level, cs, idx;
		longint unsigned ch [3];
		shade_t s;
		lx = lgt_x;
		ly = lgt_y;
		lz = lgt_z;
		hx = lx - longint'(rx);
		hy = ly - longint'(ry);
		hz = lz - longint'(rz);
		dnl = longint'(nx) * lx + longint'(ny) * ly + longint'(nz) * lz;
		dnh = longint'(nx) * hx + longint'(ny) * hy + longint'(nz) * hz;
		hh = hx * hx + hy * hy + hz * hz;
		diff = 0;
		spec = 0;
		if (dnl > 0)
			diff = round_shift(round_shift(dnl, FRAC) * gain_d, FRAC);
		if (dnh > 0 && hh != 0) begin
			len = floor_sqrt(hh);
			c = (($unsigned(dnh) << FRAC) + (len >> 1)) / len;
			if (c > ONE)
				c = ONE;
			for (int i = 0; i < 4; i++)
				c = round_shift(c * c, FRAC);
			spec = round_shift(c * gain_s, FRAC);
		end
		sum = amb + diff + spec;
		lum = round_shift(sum * fog_attenuation(dst), 30);
		if (lum > ONE)
			lum = ONE;
		level = (lum * 9 + (ONE >> 1)) >> FRAC;
		if (level > 9)
			level = 9;
		idx = (mat < MAT_LIMIT && mat < LISTED) ? mat : 0;
		cs = ((64'd3 << FRAC) + 5) / 10 + round_shift((((64'd7 << FRAC) + 5) / 10) * lum, FRAC);
		for (int i = 0; i < 3; i++) begin
			ch[i] = (longint'(MAT_RGB[idx][i]) * cs) >> FRAC;
			if (ch[i] > 5)
				ch[i] = 5;
		end
		s.level = level[3:0];
		s.glyph = 7'(RAMP[int'(level)]);
		s.color = 8'(16 + 36 * ch[0] + 6 * ch[1] + ch[2]);
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		shade_t want;
		if (!arst_n) begin
			lgt_x = RST_LIGHT_X;
			lgt_y = RST_LIGHT_Y;
			lgt_z = RST_LIGHT_Z;
			amb = RST_AMBIENT;
			gain_d = RST_DIFFUSE;
			gain_s = RST_SPECULAR;
			fog_k = RST_FOG_RATE;
			expected_shades.delete();
			failures = 0;
		end else begin
			if (cfg_write) begin
				case (reg_idx_t'(cfg_index))
					REG_LIGHT_X: lgt_x = cfg_data;
					REG_LIGHT_Y: lgt_y = cfg_data;
					REG_LIGHT_Z: lgt_z = cfg_data;
					REG_AMBIENT: amb = cfg_data[14:0];
					REG_DIFFUSE: gain_d = cfg_data[14:0];
					REG_SPECULAR: gain_s = cfg_data[14:0];
					REG_FOG_RATE: fog_k = cfg_data;
					default: ;
				endcase
			end
			if (pixel_valid && !pixel_stall)
				expected_shades.push_back(predict_shade(normal_x, normal_y, normal_z,
					ray_x, ray_y, ray_z, mat_sel, hit_distance));
			if (shade_valid && !shade_stall) begin
				if (expected_shades.size() == 0) begin
					$error("shade word with no pixel word outstanding");
					failures++;
				end else begin
					want = expected_shades.pop_front();
					if (ramp_level !== want.level) begin
						$error("ramp_level expected %0d got %0d", want.level, ramp_level);
						failures++;
					end
					if (glyph_code !== want.glyph) begin
						$error("glyph_code expected %0d got %0d", want.glyph, glyph_code);
						failures++;
					end
					if (fg_color !== want.color) begin
						$error("fg_color expected %0d got %0d", want.color, fg_color);
						failures++;
					end
				end
			end
		end
		pending = expected_shades.size();
	end

endmodule

`default_nettype wire

// ===== bench/blinn_phong_ascii_shader_test.sv =====
// ----------------------------------------------------------------------------
// blinn_phong_ascii_shader_test
// drives directed and random pixel words through the shader over several
// register settings with random idling on both sides, a long output hold-off
// and drains between settings; the checker scores every shade word
// ----------------------------------------------------------------------------
`default_nettype none

module blinn_phong_ascii_shader_test import bps_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic pixel_valid = 1'b0;
	logic pixel_stall;
	logic signed [15:0] normal_x = '0, normal_y = '0, normal_z = '0;
	logic signed [15:0] ray_x = '0, ray_y = '0, ray_z = '0;
	logic [3:0] mat_sel = '0;
	logic [15:0] hit_distance = '0;
	logic shade_valid;
	logic shade_stall = 1'b0;
	logic [3:0] ramp_level;
	logic [6:0] glyph_code;
	logic [7:0] fg_color;
	int failures, pending;
	int cycles = 0;
	bit long_hold = 0;
	bit no_idle = 0;

	blinn_phong_ascii_shader uut (.*);

	blinn_phong_ascii_shader_check checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("blinn_phong_ascii_shader regression: fail");
			$finish;
		end
	end

	// receiver: random stall per word, one long hold-off on request
	initial begin
		int w;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			w = long_hold ? 300 : (no_idle ? 0 : $urandom_range(0, 3));
			long_hold = 0;
			if (w > 0) begin
				shade_stall <= 1'b1;
				repeat (w) @(negedge clk);
			end
			shade_stall <= 1'b0;
			@(posedge clk);
			while (!shade_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	task automatic send_pixel(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
		logic [15:0] rx, logic [15:0] ry, logic [15:0] rz, logic [3:0] mat, logic [15:0] dst);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pixel_valid <= 1'b1;
		normal_x <= nx;
		normal_y <= ny;
		normal_z <= nz;
		ray_x <= rx;
		ray_y <= ry;
		ray_z <= rz;
		mat_sel <= mat;
		hit_distance <= dst;
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		pixel_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t r, logic [15:0] d);
		cfg_write <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		@(negedge clk);
	endtask

	task automatic load_regs(logic [15:0] lx, logic [15:0] ly, logic [15:0] lz,
		logic [15:0] amb, logic [15:0] gd, logic [15:0] gs, logic [15:0] fog);
		write_reg(REG_LIGHT_X, lx);
		write_reg(REG_LIGHT_Y, ly);
		write_reg(REG_LIGHT_Z, lz);
		write_reg(REG_AMBIENT, amb);
		write_reg(REG_DIFFUSE, gd);
		write_reg(REG_SPECULAR, gs);
		write_reg(REG_FOG_RATE, fog);
		cfg_write <= 1'b0;
	endtask

	function automatic logic [15:0] rand_comp();
		if ($urandom_range(0, 9) < 8)
			return 16'($urandom_range(0, 32768) - 16384);
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] rand_dist();
		if ($urandom_range(0, 2) == 0)
			return 16'($urandom);
		return 16'($urandom_range(0, 4095));
	endfunction

	task automatic random_pixels(int n);
		repeat (n) begin
			if ($urandom_range(0, 9) == 0)
				send_pixel(rand_comp(), rand_comp(), rand_comp(), 16'(-$signed(rand_comp()) / 4),
					rand_comp(), rand_comp(), 4'($urandom_range(0, 15)), rand_dist());
			else
				send_pixel(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
					rand_comp(), 4'($urandom_range(0, 15)), rand_dist());
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset registers
		send_pixel(16'sd7077, 16'sd14154, 16'sd4246, 16'sd0, 16'sd0, -16'sd16384, 4'd0, 16'd0);
		send_pixel(16'sd7077, 16'sd14154, 16'sd4246, 16'sd7077, 16'sd14154, 16'sd4246,
			4'd1, 16'd0);
		send_pixel(16'sd16384, 16'sd16384, 16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384,
			4'd8, 16'd0);
		send_pixel(-16'sd16384, -16'sd16384, -16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384,
			4'd9, 16'd65535);
		send_pixel(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 4'd15, 16'd1024);
		send_pixel(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 4'd2, 16'd20480);
		send_pixel(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 4'd3, 16'd512);
		for (int m = 4; m < 16; m++)
			send_pixel(16'sd4000, 16'sd14000, 16'sd6000, 16'sd0, -16'sd3000, -16'sd16000,
				4'(m), 16'(m * 300));
		drain();

		// extremes, low end
		load_regs(16'sd16384, 16'sd0, 16'sd0, 16'd0, 16'd16384, 16'd16384, 16'd0);
		send_pixel(16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 4'd5, 16'd65535);
		send_pixel(16'sd16384, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 4'd7, 16'd65535);
		long_hold = 1;
		random_pixels(140);
		drain();

		// extremes, high end and heavy fog
		load_regs(-16'sd16384, 16'sd0, 16'sd16384, 16'd16384, 16'd0, 16'd0, 16'd65535);
		send_pixel(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 4'd0, 16'd12287);
		send_pixel(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 4'd0, 16'd12288);
		random_pixels(130);
		drain();

		// nominal light, full gains, no idling
		no_idle = 1;
		load_regs(16'sd7077, 16'sd14154, 16'sd4246, 16'd3277, 16'd16384, 16'd16384, 16'd800);
		random_pixels(130);
		no_idle = 0;
		drain();

		repeat (4) begin
			load_regs(rand_comp(), rand_comp(), rand_comp(), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom));
			random_pixels(110);
			drain();
		end

		if (failures == 0 && pending == 0)
			$display("blinn_phong_ascii_shader regression: pass");
		else
			$display("blinn_phong_ascii_shader regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+design
design/bps_pkg.sv
design/bps_front.sv
design/bps_queue.sv
design/bps_back.sv
design/blinn_phong_ascii_shader.sv
bench/blinn_phong_ascii_shader_check.sv
bench/blinn_phong_ascii_shader_test.sv
